### hw/rtl/rpe_pkg.sv
// Shared constants, types and tables for the 3D Euler rotation block.
// Used by the controller, datapath and top level; no dependencies.
package rpe_pkg;

   localparam int CordicIterations = 16;
   localparam int AtanEntries      = 24;
   localparam int NumIter          = (CordicIterations < AtanEntries) ?
                                     CordicIterations : AtanEntries;
   localparam int IterW            = $clog2(AtanEntries + 1);

   localparam logic signed [35:0] GainInv  = 36'sd652032874;
   localparam logic signed [35:0] PiQ30    = 36'sd3373259426;
   localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;

   localparam logic [1:0] RegAngleX = 2'd0;
   localparam logic [1:0] RegAngleY = 2'd1;
   localparam logic [1:0] RegAngleZ = 2'd2;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_CORDIC_LOAD = 4'd1,
      OP_CORDIC_STEP = 4'd2,
      OP_CORDIC_DONE = 4'd3,
      OP_MAT_CLEAR   = 4'd4,
      OP_MAT_MAC     = 4'd5,
      OP_MAT_WRITE   = 4'd6,
      OP_PT_CLEAR    = 4'd7,
      OP_PT_MAC      = 4'd8,
      OP_PT_WRITE    = 4'd9,
      OP_MAT_COPY    = 4'd10
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [1:0]           axis;   // CORDIC angle select
      logic [IterW-1:0]     iter;   // CORDIC iteration
      logic [1:0]           row;
      logic [1:0]           col;
      logic [1:0]           k;      // product term
      logic                 stage;  // 0: Ry*Rx, 1: Rz*tmp
   } cmd_type;

   function automatic logic signed [35:0] atan_q30(input logic [IterW-1:0] i);
      logic signed [35:0] r;
      begin
         case (i)
            5'd0:  r = 36'sd843314856;
            5'd1:  r = 36'sd497837829;
            5'd2:  r = 36'sd263043836;
            5'd3:  r = 36'sd133525158;
            5'd4:  r = 36'sd67021686;
            5'd5:  r = 36'sd33543515;
            5'd6:  r = 36'sd16775850;
            5'd7:  r = 36'sd8388437;
            5'd8:  r = 36'sd4194282;
            5'd9:  r = 36'sd2097149;
            5'd10: r = 36'sd1048575;
            5'd11: r = 36'sd524287;
            5'd12: r = 36'sd262143;
            5'd13: r = 36'sd131071;
            5'd14: r = 36'sd65535;
            5'd15: r = 36'sd32767;
            5'd16: r = 36'sd16383;
            5'd17: r = 36'sd8191;
            5'd18: r = 36'sd4095;
            5'd19: r = 36'sd2047;
            5'd20: r = 36'sd1023;
            5'd21: r = 36'sd511;
            5'd22: r = 36'sd255;
            5'd23: r = 36'sd127;
            default: r = 36'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

### hw/rtl/rpe_datapath.sv
// Datapath: CORDIC sine/cosine, matrix build and point transform on one
// shared 18x24 multiplier with a 48-bit accumulator. Depends on rpe_pkg.
module rpe_datapath
   import rpe_pkg::*;
(
   input  logic                clock,
   input  cmd_type             cmd,
   input  logic signed [15:0]  angle_x,
   input  logic signed [15:0]  angle_y,
   input  logic signed [15:0]  angle_z,
   input  logic signed [23:0]  px,
   input  logic signed [23:0]  py,
   input  logic signed [23:0]  pz,
   output logic signed [23:0]  x_out,
   output logic signed [23:0]  y_out,
   output logic signed [23:0]  z_out,
   output logic                sat_out
);

   // CORDIC state (Q.30 in 36 bits)
   logic signed [35:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic               neg_ff, neg_in;
   // sin/cos per axis, Q2.16
   logic signed [17:0] sin_ff [3];
   logic signed [17:0] cos_ff [3];
   logic signed [17:0] tmp_ff [9];
   logic signed [17:0] mat_ff [9];
   logic signed [47:0] acc_ff, acc_in;
   logic signed [23:0] res_ff [3];
   logic [2:0]         sat_ff;

   logic signed [15:0] ang;
   logic signed [35:0] zs, dx, dy, xf, yf;
   logic signed [35:0] xr, yr;
   logic signed [17:0] c18, s18;
   logic signed [17:0] ma;
   logic signed [23:0] mb;
   logic signed [41:0] prod;
   logic signed [47:0] rnd;
   logic signed [17:0] m18;
   logic               sat24;
   logic signed [23:0] v24;

   function automatic logic signed [17:0] sat18(input logic signed [35:0] v);
      if (v > 36'sd131071)       return 18'sh1ffff;
      else if (v < -36'sd131072) return -18'sd131072;
      else                       return v[17:0];
   endfunction

   // Element of Rx, Ry, Rz for the current (row, col)
   function automatic logic signed [17:0] rot_elem(input logic [1:0] ax,
         input logic [1:0] r, input logic [1:0] c,
         input logic signed [17:0] s, input logic signed [17:0] co);
      logic [1:0] a, b;
      begin
         // map to plane indexes: for X (1,2), Y (0,2), Z (0,1)
         a = (ax == RegAngleX) ? 2'd1 : 2'd0;
         b = (ax == RegAngleZ) ? 2'd1 : 2'd2;
         if (r != a && r != b) return (r == c) ? 18'sd65536 : 18'sd0;
         if (c != a && c != b) return 18'sd0;
         if (r == c) return co;
         if (ax == RegAngleY) return (r == a) ? -s : s;
         return (r == a) ? -s : s;
      end
   endfunction

   always_comb begin
      unique case (cmd.axis)
         RegAngleX: ang = angle_x;
         RegAngleY: ang = angle_y;
         default:   ang = angle_z;
      endcase
      zs = 36'(ang) <<< 17;
      dx = cy_ff >>> cmd.iter;
      dy = cx_ff >>> cmd.iter;
      xf = neg_ff ? -cx_ff : cx_ff;
      yf = neg_ff ? -cy_ff : cy_ff;
      xr = (xf + 36'sd8192) >>> 14;
      yr = (yf + 36'sd8192) >>> 14;
      c18 = sat18(xr);
      s18 = sat18(yr);

      // multiplier operands
      if (cmd.stage == 1'b0) begin
         ma = rot_elem(RegAngleY, cmd.row, cmd.k, sin_ff[1], cos_ff[1]);
         mb = 24'(rot_elem(RegAngleX, cmd.k, cmd.col, sin_ff[0], cos_ff[0]));
      end else begin
         ma = rot_elem(RegAngleZ, cmd.row, cmd.k, sin_ff[2], cos_ff[2]);
         mb = 24'(tmp_ff[{2'b0, cmd.k} * 4'd3 + {2'b0, cmd.col}]);
      end
      if (cmd.op == OP_PT_MAC) begin
         ma = mat_ff[{2'b0, cmd.row} * 4'd3 + {2'b0, cmd.k}];
         unique case (cmd.k)
            2'd0:    mb = px;
            2'd1:    mb = py;
            default: mb = pz;
         endcase
      end
      prod = ma * mb;

      rnd = (acc_ff + 48'sd32768) >>> 16;
      m18 = sat18(rnd[35:0]);
      if (rnd > 48'sd8388607) begin
         v24 = 24'sh7fffff; sat24 = 1'b1;
      end else if (rnd < -48'sd8388608) begin
         v24 = -24'sd8388608; sat24 = 1'b1;
      end else begin
         v24 = rnd[23:0]; sat24 = 1'b0;
      end

      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; neg_in = neg_ff;
      acc_in = acc_ff;
      unique case (cmd.op)
         OP_CORDIC_LOAD: begin
            cx_in = GainInv; cy_in = '0; neg_in = 1'b0; cz_in = zs;
            if (zs > HalfPiQ30) begin
               cz_in = zs - PiQ30; neg_in = 1'b1;
            end else if (zs < -HalfPiQ30) begin
               cz_in = zs + PiQ30; neg_in = 1'b1;
            end
         end
         OP_CORDIC_STEP: begin
            if (!cz_ff[35]) begin
               cx_in = cx_ff - dx; cy_in = cy_ff + dy;
               cz_in = cz_ff - atan_q30(cmd.iter);
            end else begin
               cx_in = cx_ff + dx; cy_in = cy_ff - dy;
               cz_in = cz_ff + atan_q30(cmd.iter);
            end
         end
         OP_MAT_CLEAR, OP_PT_CLEAR: acc_in = '0;
         OP_MAT_MAC, OP_PT_MAC:     acc_in = acc_ff + 48'(prod);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; neg_ff <= neg_in;
      acc_ff <= acc_in;
      unique case (cmd.op)
         OP_CORDIC_DONE: begin
            sin_ff[cmd.axis] <= s18;
            cos_ff[cmd.axis] <= c18;
         end
         OP_MAT_WRITE: begin
            if (cmd.stage == 1'b0) tmp_ff[{2'b0, cmd.row} * 4'd3 + {2'b0, cmd.col}] <= m18;
            else                   mat_ff[{2'b0, cmd.row} * 4'd3 + {2'b0, cmd.col}] <= m18;
         end
         OP_PT_WRITE: begin
            res_ff[cmd.row] <= v24;
            sat_ff[cmd.row] <= sat24;
         end
         default: ;
      endcase
   end

   assign x_out   = res_ff[0];
   assign y_out   = res_ff[1];
   assign z_out   = res_ff[2];
   assign sat_out = |sat_ff;

endmodule

### hw/rtl/rpe_ctrl.sv
// Controller: sequences CORDIC, matrix build and per-point MACs.
// Depends on rpe_pkg; drives rpe_datapath through cmd_type.
module rpe_ctrl
   import rpe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,        // word accepted
   input  logic    matrix_ready,
   input  logic    out_free,     // output register free or being taken
   output logic    busy,
   output logic    built,        // matrix build finished
   output logic    done,         // load result into output stage
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CORD  = 5'b00010,
      S_MAT   = 5'b00100,
      S_PT    = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IterW:0]   cnt_ff, cnt_in;   // CORDIC: 0 load, 1..N step, N+1 done
   logic [1:0]       axis_ff, axis_in, row_ff, row_in, col_ff, col_in;
   logic [2:0]       ph_ff, ph_in;     // 0 clear, 1..3 mac, 4 write
   logic             stg_ff, stg_in;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; axis_in = axis_ff;
      row_in = row_ff; col_in = col_ff; ph_in = ph_ff; stg_in = stg_ff;
      cmd = '0; cmd.op = OP_NONE;
      cmd.axis = axis_ff; cmd.row = row_ff; cmd.col = col_ff; cmd.stage = stg_ff;
      cmd.iter = cnt_ff[IterW-1:0] - IterW'(1);
      cmd.k = (ph_ff == 3'd0) ? 2'd0 : 2'(ph_ff - 3'd1);
      built = 1'b0; done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cnt_in = '0; axis_in = '0; row_in = '0; col_in = '0;
               ph_in = '0; stg_in = 1'b0;
               state_in = matrix_ready ? S_PT : S_CORD;
            end
         end
         S_CORD: begin
            if (cnt_ff == '0) cmd.op = OP_CORDIC_LOAD;
            else if (cnt_ff == (IterW+1)'(NumIter + 1)) cmd.op = OP_CORDIC_DONE;
            else cmd.op = OP_CORDIC_STEP;
            cnt_in = cnt_ff + (IterW+1)'(1);
            if (cnt_ff == (IterW+1)'(NumIter + 1)) begin
               cnt_in = '0;
               axis_in = axis_ff + 2'd1;
               if (axis_ff == RegAngleZ) state_in = S_MAT;
            end
         end
         S_MAT, S_PT: begin
            if (ph_ff == 3'd0) cmd.op = (state_ff == S_MAT) ? OP_MAT_CLEAR : OP_PT_CLEAR;
            else if (ph_ff == 3'd4) cmd.op = (state_ff == S_MAT) ? OP_MAT_WRITE : OP_PT_WRITE;
            else cmd.op = (state_ff == S_MAT) ? OP_MAT_MAC : OP_PT_MAC;
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd4) begin
               ph_in = '0;
               if (state_ff == S_PT) begin
                  row_in = row_ff + 2'd1;
                  if (row_ff == 2'd2) begin
                     row_in = '0; state_in = S_OUT;
                  end
               end else begin
                  col_in = col_ff + 2'd1;
                  if (col_ff == 2'd2) begin
                     col_in = '0; row_in = row_ff + 2'd1;
                     if (row_ff == 2'd2) begin
                        row_in = '0;
                        if (stg_ff) begin
                           built = 1'b1; state_in = S_PT;
                        end else stg_in = 1'b1;
                     end
                  end
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               done = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in; axis_ff <= axis_in; row_ff <= row_in;
      col_ff <= col_in; ph_ff <= ph_in; stg_ff <= stg_in;
   end

endmodule

### hw/rtl/rotate_points_3d_euler.sv
// Rotates Q16.8 points by R = Rz*Ry*Rx built from CORDIC sine/cosine.
// Per output row, each point runs a clear, multiply-accumulates and a write on
// the shared multiplier, then waits for a free output register; a new point is
// taken only when idle. After reset or an angle write, the matrix is rebuilt first.
// Synchronous active-high reset clears angles, matrix-ready and handshakes.
module rotate_points_3d_euler
   import rpe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_x_in,
   input  logic signed [23:0] req_y_in,
   input  logic signed [23:0] req_z_in,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_x_out,
   output logic signed [23:0] rsp_y_out,
   output logic signed [23:0] rsp_z_out,
   output logic               rsp_last,
   output logic               rsp_saturated,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic               rdy_ff;
   logic signed [23:0] px_ff, py_ff, pz_ff;
   logic               lp_ff;
   logic               ov_ff;
   logic signed [23:0] ox_ff, oy_ff, oz_ff;
   logic               ol_ff, os_ff;
   logic               start, busy, built, done, wr;
   logic signed [23:0] dx, dy, dz;
   logic               dsat;
   cmd_type            cmd;

   assign pready    = 1'b1;
   assign wr        = psel && penable && pwrite;
   assign req_ready = !busy;
   assign start     = req_valid && req_ready;

   always_comb begin
      unique case (paddr[3:2])
         RegAngleX: prdata = 32'(ax_ff);
         RegAngleY: prdata = 32'(ay_ff);
         RegAngleZ: prdata = 32'(az_ff);
         default:   prdata = '0;
      endcase
   end

   rpe_ctrl u_ctrl (
      .clock, .reset, .start, .matrix_ready(rdy_ff),
      .out_free(!ov_ff || rsp_ready), .busy, .built, .done, .cmd
   );

   rpe_datapath u_dp (
      .clock, .cmd, .angle_x(ax_ff), .angle_y(ay_ff), .angle_z(az_ff),
      .px(px_ff), .py(py_ff), .pz(pz_ff),
      .x_out(dx), .y_out(dy), .z_out(dz), .sat_out(dsat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0; ay_ff <= '0; az_ff <= '0;
         rdy_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         if (wr) begin
            // drop writes to unused addresses, keep the matrix
            unique case (paddr[3:2])
               RegAngleX: begin
                  ax_ff <= pwdata[15:0]; rdy_ff <= 1'b0;
               end
               RegAngleY: begin
                  ay_ff <= pwdata[15:0]; rdy_ff <= 1'b0;
               end
               RegAngleZ: begin
                  az_ff <= pwdata[15:0]; rdy_ff <= 1'b0;
               end
               default: ;
            endcase
         end else if (built) begin
            rdy_ff <= 1'b1;
         end
         if (done)                 ov_ff <= 1'b1;
         else if (rsp_ready)       ov_ff <= 1'b0;
      end
      if (start) begin
         px_ff <= req_x_in; py_ff <= req_y_in; pz_ff <= req_z_in;
         lp_ff <= req_last_point;
      end
      if (done) begin
         ox_ff <= dx; oy_ff <= dy; oz_ff <= dz; ol_ff <= lp_ff; os_ff <= dsat;
      end
   end

   assign rsp_valid     = ov_ff;
   assign rsp_x_out     = ox_ff;
   assign rsp_y_out     = oy_ff;
   assign rsp_z_out     = oz_ff;
   assign rsp_last      = ol_ff;
   assign rsp_saturated = os_ff;

`ifndef NO_ASSERTIONS
   // the controller must not finish a point while the output word is held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> (!ov_ff || rsp_ready)) else $error("result overwritten");
   // no new word is taken while one is in flight
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start |=> busy) else $error("controller missed start");
   // matrix is only marked valid by a finished build
   a_ready_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rdy_ff) |-> $past(built)) else $error("matrix valid without build");
`endif

endmodule

### test/tb_top.sv
// Testbench for rotate_points_3d_euler: directed table, then random point sets.
// Depends on rpe_pkg and the block's RTL.
// An internal predictor (CORDIC, matrix build, point rotation) checks untyped rows.
`timescale 1ns / 1ps

module tb_top;
   import rpe_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int LongHold      = 400;
   localparam int Iters         = (CordicIterations < 24) ? CordicIterations : 24;

   typedef struct {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic               last;
      logic               sat;
   } point_type;

   typedef struct {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic               last;
      bit                 typed;    // expectation written into the row
      logic signed [23:0] ex, ey, ez;
      logic               esat;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [23:0] req_x_in = '0, req_y_in = '0, req_z_in = '0;
   logic               req_last_point = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_x_out, rsp_y_out, rsp_z_out;
   logic               rsp_last, rsp_saturated;
   logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   rotate_points_3d_euler dut (.*);

   always #2 clock = ~clock;

   // predictor state
   logic [15:0] angle_reg [3];
   longint      rot_mat [9];
   bit          mat_valid;
   longint      atan_tab [24] = '{843314856, 497837829, 263043836, 133525158,
                                  67021686, 33543515, 16775850, 8388437,
                                  4194282, 2097149, 1048575, 524287,
                                  262143, 131071, 65535, 32767,
                                  16383, 8191, 4095, 2047, 1023, 511, 255, 127};

   point_type expected_points [$];
   int     mismatches = 0;
   int     points_sent = 0;
   int     points_checked = 0;
   int     sat_seen = 0;
   int     idle_cycles = 0;
   bit     hold_request = 0;
   bit     no_idle = 0;

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   task automatic cordic_sin_cos(input logic [15:0] a, output longint s, output longint c);
      longint zz, xx, yy, dx, dy;
      bit     flip;
      zz = longint'($signed(a)) * 131072;
      xx = 652032874;
      yy = 0;
      flip = 0;
      if (zz > 1686629713) begin
         zz -= 64'sd3373259426; flip = 1;
      end else if (zz < -1686629713) begin
         zz += 64'sd3373259426; flip = 1;
      end
      for (int i = 0; i < Iters; i++) begin
         dx = yy >>> i;
         dy = xx >>> i;
         if (zz >= 0) begin
            xx -= dx; yy += dy; zz -= atan_tab[i];
         end else begin
            xx += dx; yy -= dy; zz += atan_tab[i];
         end
      end
      if (flip) begin
         xx = -xx; yy = -yy;
      end
      c = clip((xx + 8192) >>> 14, -131072, 131071);
      s = clip((yy + 8192) >>> 14, -131072, 131071);
   endtask

   task automatic mat_product(input longint a [9], input longint b [9], output longint r [9]);
      longint acc;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = a[i*3] * b[j] + a[i*3+1] * b[3+j] + a[i*3+2] * b[6+j];
            r[i*3+j] = clip((acc + 32768) >>> 16, -131072, 131071);
         end
   endtask

   task automatic build_rotation();
      longint sx, cx, sy, cy, sz, cz;
      longint rx [9], ry [9], rz [9], tmp [9], res [9];
      cordic_sin_cos(angle_reg[0], sx, cx);
      cordic_sin_cos(angle_reg[1], sy, cy);
      cordic_sin_cos(angle_reg[2], sz, cz);
      rx = '{65536, 0, 0, 0, cx, -sx, 0, sx, cx};
      ry = '{cy, 0, -sy, 0, 65536, 0, sy, 0, cy};
      rz = '{cz, -sz, 0, sz, cz, 0, 0, 0, 65536};
      mat_product(ry, rx, tmp);
      mat_product(rz, tmp, res);
      rot_mat = res;
      mat_valid = 1;
   endtask

   task automatic rotate_point(input stim_row_type r, output point_type p);
      longint acc, v;
      longint c [3];
      logic signed [23:0] o [3];
      bit clipped;
      if (!mat_valid) build_rotation();
      c[0] = r.x; c[1] = r.y; c[2] = r.z;
      clipped = 0;
      for (int i = 0; i < 3; i++) begin
         acc = rot_mat[i*3] * c[0] + rot_mat[i*3+1] * c[1] + rot_mat[i*3+2] * c[2];
         v = (acc + 32768) >>> 16;
         if (v > 8388607 || v < -8388608) clipped = 1;
         o[i] = 24'(clip(v, -8388608, 8388607));
      end
      p.x = o[0]; p.y = o[1]; p.z = o[2];
      p.last = r.last;
      p.sat = clipped;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d want %0d (point %0d)", what, got, want, points_checked);
      mismatches++;
   endtask

   // result checker
   always @(posedge clock) begin
      point_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            w = expected_points.pop_front();
            if (rsp_x_out !== w.x) report_mismatch("x_out", rsp_x_out, w.x);
            if (rsp_y_out !== w.y) report_mismatch("y_out", rsp_y_out, w.y);
            if (rsp_z_out !== w.z) report_mismatch("z_out", rsp_z_out, w.z);
            if (rsp_last !== w.last) report_mismatch("last", rsp_last, w.last);
            if (rsp_saturated !== w.sat) report_mismatch("saturated", rsp_saturated, w.sat);
            if (w.sat) sat_seen++;
         end
         points_checked++;
      end
   end

   // watchdog: cycles without any accepted word or register access
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Timeout after %0d idle cycles", idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            hold_request = 0;
         end
         n = no_idle ? 0 : $urandom_range(0, 3);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic csr_write(input int idx, input logic [15:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= 4'(4 * idx); pwdata <= {16'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx < 3) begin
         angle_reg[idx] = value;
         mat_valid = 0;
      end
   endtask

   task automatic drain();
      wait (expected_points.size() == 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_angles(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az);
      drain();
      csr_write(RegAngleX, ax);
      csr_write(RegAngleY, ay);
      csr_write(RegAngleZ, az);
   endtask

   // offer one word, hold it until accepted, record the prediction
   task automatic send_point(input stim_row_type r, input bit keep_valid);
      point_type p;
      int gap;
      gap = (no_idle || keep_valid) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_in <= r.x; req_y_in <= r.y; req_z_in <= r.z; req_last_point <= r.last;
      do @(posedge clock); while (!(req_valid && req_ready));
      rotate_point(r, p);
      if (r.typed) begin
         p.x = r.ex; p.y = r.ey; p.z = r.ez; p.sat = r.esat;
      end
      expected_points.push_back(p);
      points_sent++;
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_coord();
      int sel;
      sel = $urandom_range(0, 7);
      case (sel)
         0:       return 24'sd8388607;
         1:       return -24'sd8388608;
         2, 3:    return 24'($signed(16'($urandom)));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_angle();
      int sel;
      sel = $urandom_range(0, 5);
      case (sel)
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   stim_row_type directed [] = '{
      '{24'sd0, 24'sd0, 24'sd0, 1'b0, 1, 24'sd0, 24'sd0, 24'sd0, 1'b0},
      '{24'sd0, 24'sd0, 24'sd0, 1'b1, 1, 24'sd0, 24'sd0, 24'sd0, 1'b0},
      '{24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b0, 0, 0, 0, 0, 0},
      '{-24'sd8388608, -24'sd8388608, -24'sd8388608, 1'b1, 0, 0, 0, 0, 0},
      '{24'sd8388607, -24'sd8388608, 24'sd0, 1'b0, 0, 0, 0, 0, 0},
      '{24'sd256, 24'sd0, 24'sd0, 1'b0, 0, 0, 0, 0, 0},
      '{24'sd0, 24'sd256, 24'sd0, 1'b0, 0, 0, 0, 0, 0},
      '{24'sd0, 24'sd0, 24'sd256, 1'b1, 0, 0, 0, 0, 0},
      '{-24'sd1, 24'sd1, -24'sd1, 1'b0, 0, 0, 0, 0, 0},
      '{24'sh555555, 24'shAAAAAA, 24'sh0F0F0F, 1'b1, 0, 0, 0, 0, 0}
   };

   initial begin
      stim_row_type r;
      int set_len;
      for (int i = 0; i < 3; i++) angle_reg[i] = '0;
      for (int i = 0; i < 9; i++) rot_mat[i] = 0;
      mat_valid = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset angles, then extremes and right angles
      foreach (directed[i]) send_point(directed[i], 0);
      end_burst();
      set_angles(16'h7FFF, 16'h8000, 16'h7FFF);
      foreach (directed[i]) begin
         r = directed[i]; r.typed = 0;
         send_point(r, 0);
      end
      end_burst();
      set_angles(16'd6434, 16'd12868, -16'sd12868);
      // out-of-range register: ignored, matrix kept
      csr_write(3, 16'h1234);
      foreach (directed[i]) begin
         r = directed[i]; r.typed = 0;
         send_point(r, 0);
      end
      end_burst();

      // random: point sets under several angle settings
      for (int ph = 0; ph < 8; ph++) begin
         set_angles(rand_angle(), rand_angle(), rand_angle());
         no_idle = (ph == 2);
         if (ph == 4) hold_request = 1;
         for (int n = 0; n < 170; n++) begin
            set_len = $urandom_range(1, 8);
            r.x = rand_coord(); r.y = rand_coord(); r.z = rand_coord();
            r.last = ($urandom_range(0, set_len - 1) == 0);
            r.typed = 0;
            send_point(r, ph == 4);
         end
         end_burst();
         no_idle = 0;
      end

      drain();
      $display("Covered %0d points over 11 angle settings, %0d saturated results.",
               points_sent, sat_seen);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
